@@ rtl/core/stsg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sine tone generator package
// Shared constants, control structs and the reciprocal table for the
// constant divisions of the Taylor series.
// ----------------------------------------------------------------------------
package stsg_pkg;

    localparam int PHASE_BITS_DEF = 32;
    localparam int SINE_BITS_DEF  = 16;

    localparam int MUL_W = 32;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // floor(pct * 32768 / 100) == (pct * VOL_RECIP) >> VOL_SHIFT for pct < 128
    localparam logic [22:0] VOL_RECIP = 23'd5368710;
    localparam int          VOL_SHIFT = 14;

    localparam logic [15:0] SAT_POS     = 16'd32767;
    localparam logic [15:0] SAT_NEG_MAG = 16'd32768;

    // exact floor(q / d) for q < 2^30: (q * RECIP) >> SHIFT
    localparam logic [31:0] RECIP_S6 = 32'(((64'd1 << 38) + 64'd155) / 64'd156);
    localparam logic [31:0] RECIP_S5 = 32'(((64'd1 << 37) + 64'd109) / 64'd110);
    localparam logic [31:0] RECIP_S4 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
    localparam logic [31:0] RECIP_S3 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
    localparam logic [31:0] RECIP_S2 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
    localparam logic [31:0] RECIP_S1 = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
    localparam logic [31:0] RECIP_C6 = 32'(((64'd1 << 38) + 64'd131) / 64'd132);
    localparam logic [31:0] RECIP_C5 = 32'(((64'd1 << 37) + 64'd89) / 64'd90);
    localparam logic [31:0] RECIP_C4 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
    localparam logic [31:0] RECIP_C3 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
    localparam logic [31:0] RECIP_C2 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
    localparam logic [31:0] RECIP_C1 = 32'(((64'd1 << 31) + 64'd1) / 64'd2);

    typedef struct packed {
        logic start;
        logic out_free;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] recip_mul(input logic is_cos, input logic [2:0] k);
        logic [31:0] m;
        case ({is_cos, k})
            4'b0_110: m = RECIP_S6;
            4'b0_101: m = RECIP_S5;
            4'b0_100: m = RECIP_S4;
            4'b0_011: m = RECIP_S3;
            4'b0_010: m = RECIP_S2;
            4'b0_001: m = RECIP_S1;
            4'b1_110: m = RECIP_C6;
            4'b1_101: m = RECIP_C5;
            4'b1_100: m = RECIP_C4;
            4'b1_011: m = RECIP_C3;
            4'b1_010: m = RECIP_C2;
            4'b1_001: m = RECIP_C1;
            default:  m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] recip_shift(input logic is_cos, input logic [2:0] k);
        logic [5:0] s;
        case ({is_cos, k})
            4'b0_110: s = 6'd38;
            4'b0_101: s = 6'd37;
            4'b0_100: s = 6'd37;
            4'b0_011: s = 6'd36;
            4'b0_010: s = 6'd35;
            4'b0_001: s = 6'd33;
            4'b1_110: s = 6'd38;
            4'b1_101: s = 6'd37;
            4'b1_100: s = 6'd36;
            4'b1_011: s = 6'd35;
            4'b1_010: s = 6'd34;
            4'b1_001: s = 6'd31;
            default:  s = 6'd0;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/stsg_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module stsg_mul (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [stsg_pkg::MUL_W-1:0]   i_a,
    input  logic [stsg_pkg::MUL_W-1:0]   i_b,
    output logic [2*stsg_pkg::MUL_W-1:0] o_prod
);
    import stsg_pkg::*;

    logic [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= {{MUL_W{1'b0}}, i_a} * {{MUL_W{1'b0}}, i_b};
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

@@ rtl/core/stsg_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sine sample sequencer
// Octant fold, Q30 Horner series and volume scaling on the shared multiplier.
// ----------------------------------------------------------------------------
module stsg_core #(
    parameter int PHASE_BITS = stsg_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS  = stsg_pkg::SINE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  stsg_pkg::t_core_ctl   i_ctl,
    output stsg_pkg::t_core_sts   o_sts,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic [6:0]            i_amplitude_percent,
    output logic [15:0]           o_sample
);
    import stsg_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MULX  = 4'd1;
    localparam logic [3:0] ST_MULX2 = 4'd2;
    localparam logic [3:0] ST_LDX2  = 4'd3;
    localparam logic [3:0] ST_HMUL  = 4'd4;
    localparam logic [3:0] ST_HDIV  = 4'd5;
    localparam logic [3:0] ST_HUPD  = 4'd6;
    localparam logic [3:0] ST_MULS  = 4'd7;
    localparam logic [3:0] ST_MULV  = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [2:0]  r_k, n_k;
    logic [29:0] r_g;
    logic        r_cos;
    logic        r_neg;
    logic [15:0] r_vol;
    logic [29:0] r_x;
    logic [29:0] r_x2;
    logic [30:0] r_t;

    logic [1:0]              w_quad;
    logic [PHASE_BITS+29:0]  w_frac_wide;
    logic [29:0]             w_f;
    logic                    w_fold;
    logic [30:0]             w_unfold;
    logic [29:0]             w_g;
    logic [29:0]             w_vol_prod;
    logic                    w_mul_en;
    logic [MUL_W-1:0]        w_mul_a;
    logic [MUL_W-1:0]        w_mul_b;
    logic [2*MUL_W-1:0]      w_prod;
    logic [5:0]              w_rshift;
    logic [29:0]             w_quo;
    logic [SINE_BITS:0]      w_sm;
    logic [15:0]             w_mag;
    logic                    w_done;

    // octant fold of the incoming phase
    assign w_quad      = i_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign w_frac_wide = {i_phase[PHASE_BITS-3:0], 32'b0};
    assign w_f         = w_frac_wide[PHASE_BITS+29:PHASE_BITS];
    assign w_fold      = w_f[29];
    assign w_unfold    = Q30_ONE - {1'b0, w_f};
    assign w_g         = w_fold ? w_unfold[29:0] : w_f;
    assign w_vol_prod  = 30'({23'd0, i_amplitude_percent} * VOL_RECIP);

    assign w_rshift = recip_shift(r_cos, r_k);
    assign w_quo    = 30'(w_prod >> w_rshift);
    assign w_sm     = r_cos ? r_t[30:30-SINE_BITS] : w_prod[60:60-SINE_BITS];
    assign w_mag    = w_prod[SINE_BITS+15:SINE_BITS];

    assign w_mul_en = r_state inside {ST_MULX, ST_MULX2, ST_HMUL, ST_HDIV, ST_MULS, ST_MULV};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MULX: begin
                w_mul_a = 32'(r_g);
                w_mul_b = 32'(HALF_PI_Q30);
            end
            ST_MULX2: begin
                w_mul_a = 32'(w_prod[59:30]);
                w_mul_b = 32'(w_prod[59:30]);
            end
            ST_HMUL: begin
                w_mul_a = 32'(r_x2);
                w_mul_b = 32'(r_t);
            end
            ST_HDIV: begin
                w_mul_a = 32'(w_prod[59:30]);
                w_mul_b = recip_mul(r_cos, r_k);
            end
            ST_MULS: begin
                w_mul_a = 32'(r_x);
                w_mul_b = 32'(r_t);
            end
            ST_MULV: begin
                w_mul_a = 32'(r_vol);
                w_mul_b = 32'(w_sm);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    stsg_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_done = (r_state == ST_FIN) && i_ctl.out_free;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        case (r_state)
            ST_IDLE:  if (i_ctl.start) begin
                n_state = ST_MULX;
            end
            ST_MULX:  n_state = ST_MULX2;
            ST_MULX2: n_state = ST_LDX2;
            ST_LDX2: begin
                n_k     = 3'd6;
                n_state = ST_HMUL;
            end
            ST_HMUL:  n_state = ST_HDIV;
            ST_HDIV:  n_state = ST_HUPD;
            ST_HUPD: begin
                if (r_k == 3'd1) begin
                    n_state = ST_MULS;
                end else begin
                    n_k     = r_k - 3'd1;
                    n_state = ST_HMUL;
                end
            end
            ST_MULS:  n_state = ST_MULV;
            ST_MULV:  n_state = ST_FIN;
            ST_FIN:   if (i_ctl.out_free) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= 3'd0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_ctl.start) begin
            r_g   <= w_g;
            r_cos <= w_quad[0] ^ w_fold;
            r_neg <= w_quad[1];
            r_vol <= w_vol_prod[VOL_SHIFT+15:VOL_SHIFT];
        end
        if (r_state == ST_MULX2) begin
            r_x <= w_prod[59:30];
        end
        if (r_state == ST_LDX2) begin
            r_x2 <= w_prod[59:30];
            r_t  <= Q30_ONE;
        end
        if (r_state == ST_HUPD) begin
            r_t <= Q30_ONE - {1'b0, w_quo};
        end
    end

    always_comb begin
        if (r_neg) begin
            o_sample = (w_mag > SAT_NEG_MAG) ? SAT_NEG_MAG : 16'(16'd0 - w_mag);
        end else begin
            o_sample = (w_mag > SAT_POS) ? SAT_POS : w_mag;
        end
    end

    assign o_sts.busy = (r_state != ST_IDLE);
    assign o_sts.done = w_done;

endmodule
`default_nettype wire

@@ rtl/core/sine_tone_sample_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sine tone sample generator
// Phase-accumulator sine oscillator giving one signed 16-bit sample per
// request.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries the phase step, the
// amplitude in percent and the first-sample flag. Each transaction yields
// exactly one transaction on the output channel (o_out_valid / i_out_stall)
// with the sample for the current phase; the phase then advances by the step.
// A first-sample request restarts the phase at zero, so its sample is zero.
//
// Each request is worked through the shared 32x32 multiplier: two products
// for the angle, three steps per term for the six Horner terms, then the
// sine and volume products. The sample is then registered at the output.
// o_in_stall is high while a request is being worked on.
//
// The result sits in an output register; a further request is accepted while
// it waits. If the receiver still stalls when the next sample is ready, the
// sequencer holds it and keeps o_in_stall high.
// Synchronous reset clears the phase, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module sine_tone_sample_generator #(
    parameter int PHASE_BITS = stsg_pkg::PHASE_BITS_DEF,
    parameter int SINE_BITS  = stsg_pkg::SINE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [30:0] i_phase_step,
    input  logic [6:0]  i_amplitude_percent,
    input  logic        i_first_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_sample
);
    import stsg_pkg::*;

    logic [PHASE_BITS-1:0] r_phase_acc;
    logic                  r_out_valid;
    logic [15:0]           r_sample;

    logic [PHASE_BITS+31:0] w_step_wide;
    logic [PHASE_BITS-1:0]  w_pstep;
    logic [PHASE_BITS-1:0]  w_phase;
    logic                   w_accept;
    logic [15:0]            w_core_sample;
    t_core_ctl              w_ctl;
    t_core_sts              w_sts;

    // step is a fraction of a turn at 2^32; rescale to the accumulator width
    assign w_step_wide = {1'b0, i_phase_step, {PHASE_BITS{1'b0}}};
    assign w_pstep     = w_step_wide[PHASE_BITS+31:32];
    assign w_phase     = i_first_sample ? '0 : r_phase_acc;

    assign o_in_stall = w_sts.busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_ctl.start    = w_accept;
    assign w_ctl.out_free = !r_out_valid || !i_out_stall;

    stsg_core #(
        .PHASE_BITS (PHASE_BITS),
        .SINE_BITS  (SINE_BITS)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_ctl),
        .o_sts               (w_sts),
        .i_phase             (w_phase),
        .i_amplitude_percent (i_amplitude_percent),
        .o_sample            (w_core_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase_acc <= w_phase + w_pstep;
            end
            if (w_sts.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            r_sample <= w_core_sample;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

endmodule
`default_nettype wire

@@ rtl/core/stsg_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sine tone generator port checker
// Port-level properties of the generator, attached by bind.
// ----------------------------------------------------------------------------
module stsg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_sample
);

    // reset empties the output and frees the input
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid or input stall after reset");

    // an accepted transaction keeps the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after transaction");

    // a new result only comes out of a busy sequencer
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a request in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample))
        else $error("stalled output changed");

endmodule

bind sine_tone_sample_generator stsg_checker u_stsg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_sample    (o_sample)
);
`default_nettype wire
